// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is asserted.
`ifndef SYNTHESIS
`define PAF_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");
`else
`define PAF_ASSERT(lbl, clk, rstn, prop)
`endif

// Clocked assertion, also checked during reset.
`ifndef SYNTHESIS
`define PAF_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");
`else
`define PAF_ASSERT_RST(lbl, clk, prop)
`endif

`endif

// ----- rtl/paf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package paf_pkg;

    localparam int ITERATIONS_DEF      = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 13;

    localparam int COORD_W     = 16;
    localparam int FOLD_W      = COORD_W + 1;
    localparam int GUARD_SHIFT = 24;
    localparam int DATA_W      = FOLD_W + 2 + GUARD_SHIFT;
    localparam int Z_W         = 36;
    localparam int ANGLE_W     = 16;

    localparam logic [63:0] PI_Q62_QUARTER = 64'h3243F6A8885A308D;

    localparam logic signed [Z_W-1:0] PI_Q32            = 36'sh3243F6A89;
    localparam logic signed [Z_W-1:0] HALF_PI_Q32       = 36'sh1921FB544;
    localparam logic signed [Z_W-1:0] THREE_HALF_PI_Q32 = 36'sh4B65F1FCD;
    localparam logic signed [Z_W-1:0] TWO_PI_Q32        = 36'sh6487ED511;

    typedef struct packed {
        logic                     hold;
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [Z_W-1:0]    z;
    } paf_data_t;

    // atan(2^-i) in Q32 radians, rounded to nearest; elaboration only.
    function automatic logic [63:0] atan_q32(input int unsigned i);
        logic [63:0] acc;
        logic [63:0] term;
        int unsigned n;
        int unsigned sh;
        if (i == 0) begin
            acc = PI_Q62_QUARTER;
        end else begin
            acc = 64'd0;
            for (int unsigned k = 0; k < 32; k++) begin
                n  = 2 * k + 1;
                sh = i * n;
                if (sh <= 62) begin
                    term = (64'd1 << (62 - sh)) / 64'(n);
                    if (k[0]) begin
                        acc = acc - term;
                    end else begin
                        acc = acc + term;
                    end
                end
            end
        end
        return (acc + (64'd1 << 29)) >> 30;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/paf_prep.sv -----
`timescale 1ns / 1ps
`default_nettype none

module paf_prep
    import paf_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic signed [COORD_W-1:0]  x_coord,
    input  wire logic signed [COORD_W-1:0]  y_coord,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output paf_data_t                       out_data
);

    logic                      valid_reg;
    paf_data_t                 data_reg;
    paf_data_t                 data_next;
    logic signed [FOLD_W-1:0]  x_ext;
    logic signed [FOLD_W-1:0]  y_ext;
    logic signed [FOLD_W-1:0]  x_fold;
    logic signed [FOLD_W-1:0]  y_fold;
    logic                      left;

    assign x_ext = {x_coord[COORD_W-1], x_coord};
    assign y_ext = {y_coord[COORD_W-1], y_coord};
    assign left  = x_coord[COORD_W-1];

    // fold the left half-plane onto the right one
    assign x_fold = left ? -x_ext : x_ext;
    assign y_fold = left ? -y_ext : y_ext;

    always_comb begin
        data_next.hold = 1'b0;
        data_next.x = {{(DATA_W-FOLD_W-GUARD_SHIFT){x_fold[FOLD_W-1]}}, x_fold,
                       {GUARD_SHIFT{1'b0}}};
        data_next.y = {{(DATA_W-FOLD_W-GUARD_SHIFT){y_fold[FOLD_W-1]}}, y_fold,
                       {GUARD_SHIFT{1'b0}}};
        data_next.z = left ? PI_Q32 : '0;
        if (x_coord == '0) begin
            data_next.hold = 1'b1;
            if (y_coord == '0) begin
                data_next.z = '0;
            end else if (y_coord[COORD_W-1]) begin
                data_next.z = THREE_HALF_PI_Q32;
            end else begin
                data_next.z = HALF_PI_Q32;
            end
        end else if (y_coord == '0) begin
            data_next.hold = 1'b1;
            data_next.z    = left ? PI_Q32 : '0;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ----- rtl/paf_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module paf_cell
    import paf_pkg::*;
#(
    parameter int STEP = 0
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire paf_data_t  in_data,
    output logic            out_valid,
    input  wire logic       out_ready,
    output paf_data_t       out_data
);

    localparam logic signed [Z_W-1:0] ATAN_STEP = Z_W'(atan_q32(STEP));

    logic                      valid_reg;
    paf_data_t                 data_reg;
    paf_data_t                 data_next;
    logic signed [DATA_W-1:0]  x_sh;
    logic signed [DATA_W-1:0]  y_sh;

    assign x_sh = in_data.x >>> STEP;
    assign y_sh = in_data.y >>> STEP;

    always_comb begin
        data_next = in_data;
        if (!in_data.hold) begin
            if (!in_data.y[DATA_W-1]) begin
                data_next.x = in_data.x + y_sh;
                data_next.y = in_data.y - x_sh;
                data_next.z = in_data.z + ATAN_STEP;
            end else begin
                data_next.x = in_data.x - y_sh;
                data_next.y = in_data.y + x_sh;
                data_next.z = in_data.z - ATAN_STEP;
            end
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    `PAF_ASSERT(a_hold_keeps_angle, aclk, aresetn, (in_valid && in_ready && in_data.hold) |=> (out_data.z == $past(in_data.z)))

endmodule

`default_nettype wire

// ----- rtl/paf_post.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module paf_post
    import paf_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire paf_data_t            in_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [ANGLE_W-1:0]        m_angle
);

    localparam int DROP = 32 - ANGLE_FRAC_BITS;
    localparam logic [Z_W:0] HALF_LSB = (Z_W+1)'(1) << (DROP - 1);
    localparam logic [Z_W:0] CAP_RAW  = (Z_W+1)'(TWO_PI_Q32) >> DROP;
    localparam logic [Z_W:0] CAP_MAX  = (Z_W+1)'(2**ANGLE_W - 1);
    localparam logic [Z_W:0] CAP      = (CAP_RAW > CAP_MAX) ? CAP_MAX : CAP_RAW;

    logic                      valid_reg;
    logic [ANGLE_W-1:0]        angle_reg;
    logic [ANGLE_W-1:0]        angle_next;
    logic signed [Z_W:0]       wrapped;
    logic [Z_W:0]              rounded;

    always_comb begin
        wrapped = {in_data.z[Z_W-1], in_data.z};
        if (in_data.z[Z_W-1]) begin
            wrapped = wrapped + {1'b0, TWO_PI_Q32};
        end
        if (wrapped[Z_W]) begin
            wrapped = '0;
        end
        rounded = ($unsigned(wrapped) + HALF_LSB) >> DROP;
        if (rounded > CAP) begin
            angle_next = CAP[ANGLE_W-1:0];
        end else begin
            angle_next = rounded[ANGLE_W-1:0];
        end
    end

    assign in_ready = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            angle_reg <= angle_next;
        end
    end

    assign m_valid = valid_reg;
    assign m_angle = angle_reg;

    `PAF_ASSERT(a_angle_below_cap, aclk, aresetn, m_valid |-> ((Z_W+1)'(m_angle) <= CAP))

endmodule

`default_nettype wire

// ----- rtl/polar_angle_full_turn.sv -----
// Polar angle of a point over a full turn, by pipelined CORDIC vectoring.
// Input request: s_x_coord, s_y_coord (signed 16-bit), taken when s_valid
// and s_ready are both high. Result: m_angle, unsigned, the angle in radians
// times 2^ANGLE_FRAC_BITS in [0, 2*pi), rounded and capped just below 2*pi.
// Origin gives 0; points on an axis give exact multiples of pi/2.
// Pipeline from acceptance to m_valid: one fold stage, one CORDIC cell per
// iteration, one rounding stage, each a register stage.
// Throughput: one request per cycle while m_ready is high; each cell holds one
// request and hands it to its neighbor once that neighbor is ready.
// Stall: when m_ready is low the result holds in the output register; the
// cells still advance into empty slots, so s_ready stays high until every
// stage is full.
// Reset: aresetn is synchronous, active low, and empties every stage; no
// request is in flight afterwards and s_ready is high.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module polar_angle_full_turn
    import paf_pkg::*;
#(
    parameter int ITERATIONS      = ITERATIONS_DEF,
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic signed [COORD_W-1:0]  s_x_coord,
    input  wire logic signed [COORD_W-1:0]  s_y_coord,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [ANGLE_W-1:0]              m_angle
);

    logic [ITERATIONS:0] stage_valid;
    logic [ITERATIONS:0] stage_ready;
    paf_data_t           stage_data [ITERATIONS+1];

    paf_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .x_coord   (s_x_coord),
        .y_coord   (s_y_coord),
        .out_valid (stage_valid[0]),
        .out_ready (stage_ready[0]),
        .out_data  (stage_data[0])
    );

    for (genvar g = 0; g < ITERATIONS; g++) begin : g_cell
        paf_cell #(
            .STEP (g)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (stage_valid[g]),
            .in_ready  (stage_ready[g]),
            .in_data   (stage_data[g]),
            .out_valid (stage_valid[g+1]),
            .out_ready (stage_ready[g+1]),
            .out_data  (stage_data[g+1])
        );
    end

    paf_post #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_post (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (stage_valid[ITERATIONS]),
        .in_ready (stage_ready[ITERATIONS]),
        .in_data  (stage_data[ITERATIONS]),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_angle  (m_angle)
    );

    `PAF_ASSERT(a_ready_when_out_empty, aclk, aresetn, !m_valid |-> s_ready)
    `PAF_ASSERT_RST(a_reset_empties_output, aclk, !aresetn |=> !m_valid)
    `PAF_ASSERT(a_out_only_from_pipe, aclk, aresetn, (!m_valid && !stage_valid[ITERATIONS]) |=> !m_valid)

endmodule

`default_nettype wire
